// ----- rtl/core/nwhc_pkg.sv -----
// Shared types and constants of the nearest waypoint heading controller.
// Used by the core; no dependencies.
package nwhc_pkg;

  // CORDIC datapath: vectors carry a 2^16 prescale, angles are radians * 2^16.
  localparam int CORD_W = 52;
  localparam int ANG_W  = 23;
  localparam int MAX_CORDIC_STEPS = 24;

  localparam logic signed [ANG_W-1:0] ANG_PI     = 23'sd205887;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 23'sd411775;
  localparam logic signed [32:0]      ONE_Q28    = 33'sd268435456;

  localparam logic [15:0] GAIN_RESET  = 16'd6144;
  localparam logic [15:0] SPEED_RESET = 16'd200;

  // Register map, selected by paddr[2].
  localparam logic REG_HEADING_GAIN  = 1'b0;
  localparam logic REG_FORWARD_SPEED = 1'b1;

  // Input opcodes.
  localparam logic OP_WAYPOINT = 1'b0;
  localparam logic OP_POSE     = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_CORD = 6'b000100,
    S_WRAP = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // atan(2^-i) * 2^16, rounded to nearest except for i = 1, which is rounded down.
  function automatic logic signed [ANG_W-1:0] atan_ang(input logic [4:0] i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      5'd0:  a = 23'sd51472;
      5'd1:  a = 23'sd30385;
      5'd2:  a = 23'sd16055;
      5'd3:  a = 23'sd8150;
      5'd4:  a = 23'sd4091;
      5'd5:  a = 23'sd2047;
      5'd6:  a = 23'sd1024;
      5'd7:  a = 23'sd512;
      5'd8:  a = 23'sd256;
      5'd9:  a = 23'sd128;
      5'd10: a = 23'sd64;
      5'd11: a = 23'sd32;
      5'd12: a = 23'sd16;
      5'd13: a = 23'sd8;
      5'd14: a = 23'sd4;
      5'd15: a = 23'sd2;
      5'd16: a = 23'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/nwhc_in_if.sv -----
// Request channel into the heading controller: valid/ready plus item fields.
// No dependencies.
interface nwhc_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic               start_new_plan;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, opcode, pos_x, pos_y, start_new_plan,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, start_new_plan,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- rtl/core/nwhc_out_if.sv -----
// Result channel of the heading controller: valid/ready plus command fields.
// No dependencies.
interface nwhc_out_if;
  logic               valid;
  logic               ready;
  logic               plan_present;
  logic [15:0]        linear_cmd;
  logic signed [15:0] angular_cmd;
  logic [9:0]         target_index;

  modport source (output valid, plan_present, linear_cmd, angular_cmd, target_index,
                  input ready);
  modport sink   (input valid, plan_present, linear_cmd, angular_cmd, target_index,
                  output ready);
endinterface

// ----- rtl/core/nearest_waypoint_heading_controller_core.sv -----
// Nearest waypoint heading controller. A waypoint request appends to the
// path memory unless it is full. A pose request scans the path from the kept
// search index to the end, one memory read per cycle, then runs bearing and
// yaw in turn on the shared CORDIC unit, then wraps the heading error, then
// multiplies it by the gain and loads the output register. The path memory
// read port and the CORDIC iteration bound how long a pose request takes. A
// pose on an empty path skips straight to the output stage and answers with
// zero commands. A result that is still waiting holds the next pose in the
// output stage until it is taken.
// Depends on nwhc_pkg, nwhc_in_if, nwhc_out_if.
module nearest_waypoint_heading_controller_core #(
  parameter int MAX_WAYPOINTS = 1024,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  nwhc_in_if.sink     in_ch,
  nwhc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nwhc_pkg::*;

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int NSTEPS = (CORDIC_STEPS < MAX_CORDIC_STEPS) ? CORDIC_STEPS
                                                            : MAX_CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WAYPOINTS);

  state_t state_r;
  logic [15:0] gain_r, speed_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] search_r;

  logic signed [23:0] px_r, py_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0] pwz_r, pxy_r, pyy_r, pzz_r;

  // Path memory: {x, y}.
  logic [47:0] path_mem [MAX_WAYPOINTS];
  logic [47:0] rdata_r;
  logic        wr_en, rd_en;
  logic [IW-1:0] wr_addr;

  // Scan pipeline.
  logic [CW-1:0] issue_r;
  logic s0_v_r, s1_v_r, s2_v_r;
  logic [IW-1:0] s0_idx_r, s1_idx_r, s2_idx_r;
  logic signed [24:0] dx_r, dy_r, s3_dx_r, s3_dy_r;
  logic [49:0] sqx_r, sqy_r;
  logic [50:0] best_r;
  logic [50:0] sq_dist;
  logic [IW-1:0] besti_r;
  logic signed [24:0] bdx_r, bdy_r;
  logic scan_end;

  // CORDIC.
  logic signed [CORD_W-1:0] cx_r, cy_r, cx_nxt, cy_nxt, xs, ys;
  logic signed [ANG_W-1:0]  cz_r, cz_nxt, bear_r, err_r;
  logic [4:0] step_r;
  logic       phase_r, zero_r;
  logic signed [32:0] vx, vy, num, den;
  logic signed [CORD_W-1:0] ld_x, ld_y, ex, ey;
  logic signed [ANG_W-1:0]  ld_z, cord_res;
  logic       ld_zero;

  logic signed [39:0] prod_r;
  logic signed [40:0] rnd;
  logic signed [24:0] shr;
  logic signed [15:0] sat;
  logic empty_r;

  logic out_valid_r, out_plan_r;
  logic [15:0] out_lin_r;
  logic signed [15:0] out_ang_r;
  logic [9:0] out_tgt_r;

  logic in_acc, cfg_wr;
  logic [CW-1:0] base_cnt, start_cnt;

  assign in_ch.ready = state_r == S_IDLE;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FORWARD_SPEED) ? {16'd0, speed_r}
                                                          : {16'd0, gain_r};

  assign out_ch.valid        = out_valid_r;
  assign out_ch.plan_present = out_plan_r;
  assign out_ch.linear_cmd   = out_lin_r;
  assign out_ch.angular_cmd  = out_ang_r;
  assign out_ch.target_index = out_tgt_r;

  assign base_cnt  = in_ch.start_new_plan ? '0 : count_r;
  assign start_cnt = (CW'(search_r) >= count_r) ? count_r - 1'b1 : CW'(search_r);
  assign wr_en   = in_acc && in_ch.opcode == OP_WAYPOINT && base_cnt < MAX_CNT;
  assign wr_addr = base_cnt[IW-1:0];
  assign rd_en   = state_r == S_SCAN && issue_r < count_r;
  assign sq_dist = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign scan_end = !rd_en && !s0_v_r && !s1_v_r && !s2_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) path_mem[wr_addr] <= {in_ch.pos_x, in_ch.pos_y};
    if (rd_en) rdata_r <= path_mem[issue_r[IW-1:0]];
  end

  // Yaw vector from the quaternion products.
  assign num = 33'(pwz_r + pxy_r) <<< 1;
  assign den = ONE_Q28 - (33'(pyy_r + pzz_r) <<< 1);

  // CORDIC load: bearing vector at scan end, yaw vector after the bearing.
  always_comb begin
    if (state_r == S_SCAN) begin
      vx = 33'(bdx_r);
      vy = 33'(bdy_r);
    end else begin
      vx = den;
      vy = num;
    end
    ld_zero = vx == '0 && vy == '0;
    ex = CORD_W'(vx) <<< 16;
    ey = CORD_W'(vy) <<< 16;
    if (vx < 0) begin
      ld_x = -ex;
      ld_y = -ey;
      ld_z = (vy >= 0) ? ANG_PI : -ANG_PI;
    end else begin
      ld_x = ex;
      ld_y = ey;
      ld_z = '0;
    end
  end

  always_comb begin
    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    if (cy_r > 0) begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + atan_ang(step_r);
    end else begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - atan_ang(step_r);
    end
    cord_res = zero_r ? '0 : cz_nxt;
  end

  // Round Q28 to Q12 and saturate.
  always_comb begin
    rnd = 41'(prod_r) + 41'sd32768;
    shr = 25'(rnd >>> 16);
    if (shr > 25'sd32767)       sat = 16'sh7fff;
    else if (shr < -25'sd32768) sat = 16'sh8000;
    else                        sat = 16'(shr);
  end

  always_ff @(posedge clk) begin
    // Free-running product stage; quaternion regs hold steady during the scan.
    pwz_r <= 32'(qw_r * qz_r);
    pxy_r <= 32'(qx_r * qy_r);
    pyy_r <= 32'(qy_r * qy_r);
    pzz_r <= 32'(qz_r * qz_r);
    dx_r  <= 25'($signed(rdata_r[47:24])) - 25'(px_r);
    dy_r  <= 25'($signed(rdata_r[23:0])) - 25'(py_r);
    sqx_r <= 50'(dx_r * dx_r);
    sqy_r <= 50'(dy_r * dy_r);
    s3_dx_r <= dx_r;
    s3_dy_r <= dy_r;
    s1_idx_r <= s0_idx_r;
    s2_idx_r <= s1_idx_r;
    if (in_acc) begin
      px_r <= in_ch.pos_x;
      py_r <= in_ch.pos_y;
      qx_r <= in_ch.quat_x;
      qy_r <= in_ch.quat_y;
      qz_r <= in_ch.quat_z;
      qw_r <= in_ch.quat_w;
    end
    if (state_r == S_MUL) prod_r <= 40'(err_r * $signed({1'b0, gain_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      speed_r     <= SPEED_RESET;
      count_r     <= '0;
      search_r    <= '0;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      empty_r     <= 1'b0;
      phase_r     <= 1'b0;
      step_r      <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_HEADING_GAIN) gain_r  <= cfg_pwdata[15:0];
        else                                  speed_r <= cfg_pwdata[15:0];
      end
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s0_v_r <= rd_en;
      if (rd_en) begin
        s0_idx_r <= issue_r[IW-1:0];
        issue_r  <= issue_r + 1'b1;
      end
      // Squared distance lines up with the third pipeline stage.
      if (s2_v_r && sq_dist < best_r) begin
        best_r  <= sq_dist;
        besti_r <= s2_idx_r;
        bdx_r   <= s3_dx_r;
        bdy_r   <= s3_dy_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == OP_WAYPOINT) begin
              if (in_ch.start_new_plan) search_r <= '0;
              count_r <= (base_cnt < MAX_CNT) ? base_cnt + 1'b1 : base_cnt;
            end else if (count_r == '0) begin
              empty_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              empty_r <= 1'b0;
              issue_r <= start_cnt;
              besti_r <= start_cnt[IW-1:0];
              best_r  <= '1;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            search_r <= besti_r;
            cx_r     <= ld_x;
            cy_r     <= ld_y;
            cz_r     <= ld_z;
            zero_r   <= ld_zero;
            step_r   <= '0;
            phase_r  <= 1'b0;
            state_r  <= S_CORD;
          end
        end
        S_CORD: begin
          if (step_r == LAST_STEP) begin
            step_r <= '0;
            if (!phase_r) begin
              bear_r  <= cord_res;
              cx_r    <= ld_x;
              cy_r    <= ld_y;
              cz_r    <= ld_z;
              zero_r  <= ld_zero;
              phase_r <= 1'b1;
            end else begin
              err_r   <= bear_r - cord_res;
              state_r <= S_WRAP;
            end
          end else begin
            cx_r   <= cx_nxt;
            cy_r   <= cy_nxt;
            cz_r   <= cz_nxt;
            step_r <= step_r + 1'b1;
          end
        end
        S_WRAP: begin
          if (err_r > ANG_PI)       err_r <= err_r - ANG_TWO_PI;
          else if (err_r < -ANG_PI) err_r <= err_r + ANG_TWO_PI;
          else                      state_r <= S_MUL;
        end
        S_MUL: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_plan_r  <= !empty_r;
            out_lin_r   <= empty_r ? 16'd0 : speed_r;
            out_ang_r   <= empty_r ? 16'sd0 : sat;
            out_tgt_r   <= empty_r ? 10'd0 : 10'(besti_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/nwhc_checker.sv -----
// Port-level checker for the heading controller core, with its bind.
// Depends on the core's port list only.
module nwhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_plan_present,
  input logic [15:0] out_linear_cmd,
  input logic [15:0] out_angular_cmd,
  input logic [9:0]  out_target_index,
  input logic        cfg_pready
);

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angular_cmd)
      && $stable(out_target_index))
    else $error("result dropped or changed while stalled");

  // No plan means all commands are zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_plan_present |->
      out_linear_cmd == 16'd0 && out_angular_cmd == 16'd0 && out_target_index == 10'd0)
    else $error("nonzero command without a plan");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_waypoint_heading_controller_core nwhc_checker u_nwhc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_plan_present (out_ch.plan_present),
  .out_linear_cmd   (out_ch.linear_cmd),
  .out_angular_cmd  (out_ch.angular_cmd),
  .out_target_index (out_ch.target_index),
  .cfg_pready       (cfg_pready)
);
